>>> hdl/grtb_pkg.sv
`timescale 1ns / 1ps

package grtb_pkg;

  // Configuration register indexes
  localparam logic REG_SOURCE_DEPTH = 1'b0;
  localparam logic REG_COLOUR_MAP   = 1'b1;

  // Source depth codes; the unused code behaves as 4bpp
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_2BPP = 2'd1;
  localparam logic [1:0] DEPTH_4BPP = 2'd2;

  localparam int unsigned NIBBLES   = 8;
  localparam int unsigned WORD_W    = 32;
  localparam logic [3:0]  MAX_WIDTH = 4'd8;
  localparam logic [2:0]  MAX_START = 3'd7;

  // Request after clamping
  typedef struct packed {
    logic [31:0] glyph;
    logic [31:0] dest;
    logic [31:0] spill;
    logic        present;
    logic        zero;
    logic [2:0]  start;
    logic [3:0]  end_pos;
    logic [3:0]  count;
    logic        advance;
  } clamp_t;

  // Request after colour expansion and mask build
  typedef struct packed {
    logic [31:0] val;
    logic [31:0] keep;
    logic [31:0] spill_keep;
    logic [31:0] dest;
    logic [31:0] spill;
    logic [2:0]  start;
    logic        zero;
    logic        spill_wr;
    logic        advance;
  } expand_t;

  // Merged result
  typedef struct packed {
    logic [31:0] dest_result;
    logic [31:0] spill_result;
    logic        dest_write;
    logic        spill_write;
    logic        tile_advance;
  } result_t;

  // Mask of the low n nibbles of a word
  function automatic logic [31:0] low_nibbles(input logic [3:0] n);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      m[i*4 +: 4] = (4'(i) < n) ? 4'hF : 4'h0;
    end
    return m;
  endfunction

endpackage

>>> hdl/grtb_clamp.sv
`timescale 1ns / 1ps

module grtb_clamp
  import grtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  depth,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] glyph_bits,
  input  logic [3:0]  glyph_width,
  input  logic [3:0]  start_pixel,
  input  logic [31:0] dest_word,
  input  logic [31:0] spill_word,
  input  logic        spill_present,
  output logic        out_valid,
  input  logic        out_ready,
  output clamp_t      out_data
);

  clamp_t     data_next;
  logic [3:0] width_c;
  logic [2:0] start_c;
  logic [3:0] end_c;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    width_c = glyph_width[3] ? MAX_WIDTH : glyph_width;
    start_c = start_pixel[3] ? MAX_START : start_pixel[2:0];
    end_c   = {1'b0, start_c} + width_c;

    data_next.glyph   = glyph_bits;
    data_next.dest    = dest_word;
    data_next.spill   = spill_word;
    data_next.present = spill_present;
    data_next.zero    = (glyph_width == 4'd0);
    data_next.start   = start_c;
    data_next.end_pos = end_c;
    // 1bpp at width three expands one extra pixel
    data_next.count   = (depth == DEPTH_1BPP && width_c == 4'd3) ? 4'd4 : width_c;
    // zero width reports the unclamped start tile
    data_next.advance = (glyph_width == 4'd0) ? start_pixel[3] : end_c[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/grtb_expand.sv
`timescale 1ns / 1ps

module grtb_expand
  import grtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  depth,
  input  logic [63:0] colour_map,
  input  logic        in_valid,
  output logic        in_ready,
  input  clamp_t      in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output expand_t     out_data
);

  expand_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic [3:0] idx;
    logic [3:0] spill_cnt;
    idx       = '0;
    spill_cnt = in_data.end_pos - MAX_WIDTH;
    data_next.val = '0;
    for (int p = 0; p < NIBBLES; p++) begin
      case (depth)
        DEPTH_1BPP: idx = {3'b000, in_data.glyph[7-p]};
        DEPTH_2BPP: idx = {2'b00, in_data.glyph[p*2 +: 2]};
        default:    idx = in_data.glyph[p*4 +: 4];
      endcase
      if (4'(p) < in_data.count) begin
        data_next.val[p*4 +: 4] = colour_map[{idx, 2'b00} +: 4];
      end
    end
    data_next.keep       = low_nibbles({1'b0, in_data.start}) | ~low_nibbles(in_data.end_pos);
    data_next.spill_keep = ~low_nibbles(spill_cnt);
    data_next.dest       = in_data.dest;
    data_next.spill      = in_data.spill;
    data_next.start      = in_data.start;
    data_next.zero       = in_data.zero;
    data_next.spill_wr   = !in_data.zero && in_data.present && (in_data.end_pos > MAX_WIDTH);
    data_next.advance    = in_data.advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/grtb_merge.sv
`timescale 1ns / 1ps

module grtb_merge
  import grtb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  expand_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     data_next;
  logic [31:0] shl;
  logic [31:0] shr;
  logic [5:0]  rshift;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    shl    = in_data.val << {in_data.start, 2'b00};
    // pixels past the right edge land in the low nibbles of the spill word
    rshift = 6'(WORD_W) - {1'b0, in_data.start, 2'b00};
    shr    = in_data.val >> rshift;

    data_next.dest_result  = in_data.zero ? in_data.dest
                                          : ((in_data.dest & in_data.keep) | shl);
    data_next.spill_result = in_data.spill_wr
                             ? ((in_data.spill & in_data.spill_keep) | shr)
                             : in_data.spill;
    data_next.dest_write   = !in_data.zero;
    data_next.spill_write  = in_data.spill_wr;
    data_next.tile_advance = in_data.advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/glyph_row_tile_blend_unit.sv
`timescale 1ns / 1ps

// Glyph row blender: merges one 1, 2 or 4 bpp glyph row, passed through a
// 16-entry colour map, into a 4bpp destination tile row and, for pixels that
// run past nibble 7, into the low nibbles of a spill tile row. A request is
// taken every cycle while the pipeline is not stalled, and its result reaches
// the output register through the three pipeline stages (clamp, colour
// expansion with mask build, shift and merge). Backpressure on the output
// stalls each stage only while it holds a request, so no request is lost or
// repeated. Write source_depth and colour_map only while the pipeline is
// empty; the configuration channel is always ready.
module glyph_row_tile_blend_unit
  import grtb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] glyph_bits, [35:32] glyph_width, [39:36] start_pixel,
  // [71:40] dest_word, [103:72] spill_word
  input  logic [103:0] s_tdata,
  // [0] spill_present
  input  logic         s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] dest_result, [63:32] spill_result
  output logic [63:0]  m_tdata,
  // [0] dest_write, [1] spill_write, [2] tile_advance
  output logic [2:0]   m_tuser
);

  logic [1:0]  source_depth;
  logic [63:0] colour_map;

  clamp_t  c_data;
  expand_t e_data;
  result_t r_data;
  logic    c_valid, c_ready;
  logic    e_valid, e_ready;

  assign cfg_ready = 1'b1;

  // hold configuration; depth keeps its low two bits
  always_ff @(posedge clk) begin
    if (rst) begin
      source_depth <= DEPTH_1BPP;
      colour_map   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_DEPTH: source_depth <= cfg_data[1:0];
        REG_COLOUR_MAP:   colour_map   <= cfg_data;
        default:          colour_map   <= colour_map;
      endcase
    end
  end

  // stage 1: clamp width and start, find span end
  grtb_clamp u_clamp (
    .clk           (clk),
    .rst           (rst),
    .depth         (source_depth),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .glyph_bits    (s_tdata[31:0]),
    .glyph_width   (s_tdata[35:32]),
    .start_pixel   (s_tdata[39:36]),
    .dest_word     (s_tdata[71:40]),
    .spill_word    (s_tdata[103:72]),
    .spill_present (s_tuser),
    .out_valid     (c_valid),
    .out_ready     (c_ready),
    .out_data      (c_data)
  );

  // stage 2: map source pixels to colours, build keep masks
  grtb_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .depth      (source_depth),
    .colour_map (colour_map),
    .in_valid   (c_valid),
    .in_ready   (c_ready),
    .in_data    (c_data),
    .out_valid  (e_valid),
    .out_ready  (e_ready),
    .out_data   (e_data)
  );

  // stage 3: shift into place and merge with destination and spill rows
  grtb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_data   (e_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (r_data)
  );

  assign m_tdata = {r_data.spill_result, r_data.dest_result};
  assign m_tuser = {r_data.tile_advance, r_data.spill_write, r_data.dest_write};

endmodule
